### rtl/core/kfb_pkg.sv
// Shared types, constants and clamp helpers for the keyframe Bezier curve block.
package kfb_pkg;

    localparam int TIME_W = 16;
    localparam int VAL_W  = 16;
    localparam int WING_W = 17;
    localparam int REC_W  = TIME_W + VAL_W + 2 * WING_W;

    localparam logic [15:0] Q_ONE      = 16'd32768;
    localparam logic [15:0] KEY_GAP    = 16'd655;
    localparam logic [15:0] ADD_T_MIN  = 16'd655;
    localparam logic [15:0] ADD_T_MAX  = 16'd32113;
    localparam logic [36:0] ROUND_HALF = 37'd16384;

    localparam logic [2:0] CMD_INIT   = 3'd0;
    localparam logic [2:0] CMD_ADD    = 3'd1;
    localparam logic [2:0] CMD_MOVE   = 3'd2;
    localparam logic [2:0] CMD_REMOVE = 3'd3;
    localparam logic [2:0] CMD_EVAL   = 3'd4;
    localparam logic [2:0] CMD_WINGS  = 3'd5;

    // One curve key as it sits in the key memory.
    typedef struct packed {
        logic [TIME_W-1:0]        tm;
        logic [VAL_W-1:0]         val;
        logic signed [WING_W-1:0] wing_l;
        logic signed [WING_W-1:0] wing_r;
    } key_rec_t;

    // Clamp a signed value to the unit range [0, 1.0].
    function automatic logic [15:0] clamp_unit(input logic signed [17:0] v);
        logic [15:0] r;
        if (v < 18'sd0) begin
            r = '0;
        end else if (v > 18'sd32768) begin
            r = Q_ONE;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Clamp a wing slope to [-1.0, 1.0].
    function automatic logic signed [16:0] clamp_wing(input logic signed [16:0] w);
        logic signed [16:0] r;
        if (w < -17'sd32768) begin
            r = -17'sd32768;
        end else if (w > 17'sd32768) begin
            r = 17'sd32768;
        end else begin
            r = w;
        end
        return r;
    endfunction

    // Clamp the time of a new key inside the end-key margins.
    function automatic logic [15:0] clamp_add_time(input logic signed [17:0] v);
        logic [15:0] r;
        if (v < $signed({2'b00, ADD_T_MIN})) begin
            r = ADD_T_MIN;
        end else if (v > $signed({2'b00, ADD_T_MAX})) begin
            r = ADD_T_MAX;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

### rtl/core/kfb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module kfb_ram #(
    parameter int WIDTH = 66,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/keyframe_bezier_curve.sv
// Top level of the keyframe Bezier curve: key memory sequencer, divider and lerp unit.
// Evaluate scans the keys, then runs the divider and the six lerps before it presents
// the result. One command is in flight at a time.
// Reset (aresetn low, synchronous) sets two keys, writing them in ST_INIT0 and ST_INIT1.
module keyframe_bezier_curve #(
    parameter int MAX_KEYS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // From bit 0: key_index[5:0], key_time[23:6], key_value[41:24], end_value[59:42],
    // wing_left[76:60], wing_right[93:77], zero fill.
    input  logic [95:0] s_tdata,
    // From bit 0: command[2:0].
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // From bit 0: curve_value[17:0], count_now[24:18], zero fill.
    output logic [31:0] m_tdata,
    // From bit 0: ok[0].
    output logic [0:0]  m_tuser
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int JW = CW + 1;

    // One-hot sequencer states.
    typedef enum logic [19:0] {
        ST_IDLE   = 20'h00001,
        ST_INIT0  = 20'h00002,
        ST_INIT1  = 20'h00004,
        ST_RMW_RD = 20'h00008,
        ST_RMW_WR = 20'h00010,
        ST_MV_A   = 20'h00020,
        ST_MV_B   = 20'h00040,
        ST_MV_C   = 20'h00080,
        ST_MV_D   = 20'h00100,
        ST_LP_RD  = 20'h00200,
        ST_LP_CK  = 20'h00400,
        ST_LP_WR  = 20'h00800,
        ST_EV_RD  = 20'h01000,
        ST_EV_CK  = 20'h02000,
        ST_EV_B1  = 20'h04000,
        ST_DIV0   = 20'h08000,
        ST_DIV    = 20'h10000,
        ST_LMUL   = 20'h20000,
        ST_LADD   = 20'h40000,
        ST_DONE   = 20'h80000
    } state_t;

    state_t state_reg, state_next;
    logic   boot_reg, boot_next;
    logic [2:0] cmd_reg, cmd_next;
    logic [5:0] idx_reg, idx_next;
    logic signed [17:0] kt_reg, kt_next;
    logic [15:0] kv_reg, kv_next;
    logic [15:0] ev_reg, ev_next;
    logic signed [16:0] wl_reg, wl_next;
    logic signed [16:0] wr_reg, wr_next;
    logic [15:0] t_reg, t_next;
    logic [CW-1:0] n_reg, n_next;
    logic signed [JW-1:0] j_reg, j_next;
    logic dir_right_reg, dir_right_next;
    logic shift_only_reg, shift_only_next;
    logic [15:0] prev_t_reg, prev_t_next;
    logic [15:0] ta_reg, ta_next, tb_reg, tb_next;
    logic [15:0] va_reg, va_next, vb_reg, vb_next;
    logic signed [16:0] wra_reg, wra_next, wlb_reg, wlb_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] span_reg, span_next;
    logic        d0_reg, d0_next;
    logic [15:0] quo_reg, quo_next;
    logic [3:0]  bit_cnt_reg, bit_cnt_next;
    logic [15:0] f_reg, f_next;
    logic signed [18:0] q0_reg, q0_next, q1_reg, q1_next, q2_reg, q2_next, q3_reg, q3_next;
    logic signed [36:0] prod_reg, prod_next;
    logic [3:0]  step_reg, step_next;
    logic        ok_reg, ok_next;
    logic        m_valid_reg, m_valid_next;
    logic [17:0] m_value_reg, m_value_next;
    logic        m_ok_reg, m_ok_next;
    logic [6:0]  m_count_reg, m_count_next;

    // Key memory port.
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    kfb_pkg::key_rec_t      ram_wrec;
    logic [kfb_pkg::REC_W-1:0] ram_rdata;
    kfb_pkg::key_rec_t      rd_rec;

    kfb_ram #(
        .WIDTH(kfb_pkg::REC_W),
        .DEPTH(MAX_KEYS)
    ) u_key_ram (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wrec),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    assign rd_rec = kfb_pkg::key_rec_t'(ram_rdata);

    // Input transaction fields.
    logic [2:0]         in_cmd;
    logic [5:0]         in_idx;
    logic signed [17:0] in_kt, in_kv, in_ev;
    logic signed [16:0] in_wl, in_wr;
    logic [7:0]         in_idx_w, n_w;
    logic               in_idx_ok, in_inner;

    assign in_cmd   = s_tuser[2:0];
    assign in_idx   = s_tdata[5:0];
    assign in_kt    = $signed(s_tdata[23:6]);
    assign in_kv    = $signed(s_tdata[41:24]);
    assign in_ev    = $signed(s_tdata[59:42]);
    assign in_wl    = $signed(s_tdata[76:60]);
    assign in_wr    = $signed(s_tdata[93:77]);
    assign in_idx_w = 8'(in_idx);
    assign n_w      = 8'(n_reg);
    assign in_idx_ok = in_idx_w < n_w;
    assign in_inner  = (in_idx_w != 8'd0) && ((in_idx_w + 8'd1) < n_w);

    // Inner-key move: clamp against the neighbors, then into the unit range.
    logic signed [18:0] mv_lo, mv_hi, mv_kt, mv_t;
    logic [15:0]        mv_tnew;

    assign mv_lo = $signed({3'b000, prev_t_reg}) + $signed({3'b000, kfb_pkg::KEY_GAP});
    assign mv_hi = $signed({3'b000, rd_rec.tm}) - $signed({3'b000, kfb_pkg::KEY_GAP});
    assign mv_kt = kt_reg;
    assign mv_t  = (mv_kt < mv_lo) ? mv_lo : ((mv_kt > mv_hi) ? mv_hi : mv_kt);
    assign mv_tnew = (mv_t < 19'sd0) ? 16'd0 :
                     ((mv_t > 19'sd32768) ? kfb_pkg::Q_ONE : mv_t[15:0]);

    // Insertion loop: walk toward the free slot while keys must pass the new one; remove uses it to shift keys only.
    logic signed [JW-1:0] j_inc, j_dec, lp_pos;
    logic lp_end, lp_cond;

    assign j_inc   = j_reg + JW'(1);
    assign j_dec   = j_reg - JW'(1);
    assign lp_pos  = dir_right_reg ? j_dec : j_inc;
    assign lp_end  = dir_right_reg ? (j_reg == $signed({1'b0, n_reg})) : j_reg[JW-1];
    assign lp_cond = shift_only_reg ||
                     (dir_right_reg ? (rd_rec.tm < t_reg) : (rd_rec.tm > t_reg));

    // Segment fraction setup and one restoring divide step per cycle.
    logic signed [16:0] dv_span, dv_diff;
    logic [16:0]        dv_rem2, dv_sub;
    logic               dv_ge;
    logic [15:0]        dv_quo;

    assign dv_span = $signed({1'b0, tb_reg}) - $signed({1'b0, ta_reg});
    assign dv_diff = $signed({1'b0, t_reg}) - $signed({1'b0, ta_reg});
    assign dv_rem2 = {rem_reg, (bit_cnt_reg == 4'd15) ? d0_reg : 1'b0};
    assign dv_ge   = dv_rem2 >= {1'b0, span_reg};
    assign dv_sub  = dv_rem2 - {1'b0, span_reg};
    assign dv_quo  = {quo_reg[14:0], dv_ge};

    // Shared lerp unit: multiply, register, then round half up and add.
    logic signed [19:0] ln_diff;
    logic signed [36:0] ln_prod, ln_sum;
    logic signed [18:0] ln_res;
    logic               ln_drop;

    assign ln_diff = $signed({q1_reg[18], q1_reg}) - $signed({q0_reg[18], q0_reg});
    assign ln_prod = ln_diff * $signed({1'b0, f_reg});
    assign ln_sum  = prod_reg + $signed(kfb_pkg::ROUND_HALF);
    assign ln_res  = q0_reg + $signed(ln_sum[33:15]);
    // Steps that only drop the stale head of the control-point queue.
    assign ln_drop = (step_reg == 4'd3) || (step_reg == 4'd6) || (step_reg == 4'd7);

    always_comb begin
        state_next      = state_reg;
        boot_next       = boot_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        kt_next         = kt_reg;
        kv_next         = kv_reg;
        ev_next         = ev_reg;
        wl_next         = wl_reg;
        wr_next         = wr_reg;
        t_next          = t_reg;
        n_next          = n_reg;
        j_next          = j_reg;
        dir_right_next  = dir_right_reg;
        shift_only_next = shift_only_reg;
        prev_t_next     = prev_t_reg;
        ta_next         = ta_reg;
        tb_next         = tb_reg;
        va_next         = va_reg;
        vb_next         = vb_reg;
        wra_next        = wra_reg;
        wlb_next        = wlb_reg;
        rem_next        = rem_reg;
        span_next       = span_reg;
        d0_next         = d0_reg;
        quo_next        = quo_reg;
        bit_cnt_next    = bit_cnt_reg;
        f_next          = f_reg;
        q0_next         = q0_reg;
        q1_next         = q1_reg;
        q2_next         = q2_reg;
        q3_next         = q3_reg;
        prod_next       = prod_reg;
        step_next       = step_reg;
        ok_next         = ok_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_value_next    = m_value_reg;
        m_ok_next       = m_ok_reg;
        m_count_next    = m_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wrec        = '0;
        ram_raddr       = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = in_cmd;
                    idx_next   = in_idx;
                    kt_next    = in_kt;
                    kv_next    = kfb_pkg::clamp_unit(in_kv);
                    ev_next    = kfb_pkg::clamp_unit(in_ev);
                    wl_next    = kfb_pkg::clamp_wing(in_wl);
                    wr_next    = kfb_pkg::clamp_wing(in_wr);
                    ok_next    = 1'b0;
                    state_next = ST_DONE;
                    case (in_cmd)
                        kfb_pkg::CMD_INIT: begin
                            state_next = ST_INIT0;
                        end
                        kfb_pkg::CMD_ADD: begin
                            if (n_w < 8'(MAX_KEYS)) begin
                                t_next          = kfb_pkg::clamp_add_time(in_kt);
                                dir_right_next  = 1'b0;
                                shift_only_next = 1'b0;
                                j_next          = $signed({1'b0, n_reg}) - JW'(1);
                                state_next      = ST_LP_RD;
                            end
                        end
                        kfb_pkg::CMD_MOVE: begin
                            if (in_inner) begin
                                state_next = ST_MV_A;
                            end else if (in_idx_ok) begin
                                state_next = ST_RMW_RD;
                            end
                        end
                        kfb_pkg::CMD_REMOVE: begin
                            if (in_inner) begin
                                dir_right_next  = 1'b1;
                                shift_only_next = 1'b1;
                                j_next          = JW'({1'b0, in_idx} + 7'd1);
                                state_next      = ST_LP_RD;
                            end
                        end
                        kfb_pkg::CMD_EVAL: begin
                            t_next     = kfb_pkg::clamp_unit(in_kt);
                            j_next     = '0;
                            state_next = ST_EV_RD;
                        end
                        kfb_pkg::CMD_WINGS: begin
                            if (in_idx_ok) begin
                                state_next = ST_RMW_RD;
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_INIT0: begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(0);
                ram_wrec   = '{tm: 16'd0, val: kv_reg, wing_l: '0, wing_r: '0};
                state_next = ST_INIT1;
            end
            ST_INIT1: begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(1);
                ram_wrec   = '{tm: kfb_pkg::Q_ONE, val: ev_reg, wing_l: '0, wing_r: '0};
                n_next     = CW'(2);
                ok_next    = 1'b1;
                boot_next  = 1'b0;
                state_next = boot_reg ? ST_IDLE : ST_DONE;
            end
            ST_RMW_RD: begin
                ram_raddr  = AW'(idx_reg);
                state_next = ST_RMW_WR;
            end
            ST_RMW_WR: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(idx_reg);
                ram_wrec  = rd_rec;
                if (cmd_reg == kfb_pkg::CMD_MOVE) begin
                    ram_wrec.val = kv_reg;
                end else begin
                    ram_wrec.wing_l = wl_reg;
                    ram_wrec.wing_r = wr_reg;
                end
                ok_next    = 1'b1;
                state_next = ST_DONE;
            end
            ST_MV_A: begin
                ram_raddr  = AW'(idx_reg - 6'd1);
                state_next = ST_MV_B;
            end
            ST_MV_B: begin
                ram_raddr   = AW'(idx_reg);
                prev_t_next = rd_rec.tm;
                state_next  = ST_MV_C;
            end
            ST_MV_C: begin
                ram_raddr  = AW'(idx_reg + 6'd1);
                wl_next    = rd_rec.wing_l;
                wr_next    = rd_rec.wing_r;
                state_next = ST_MV_D;
            end
            ST_MV_D: begin
                // rd_rec holds the right neighbor here.
                t_next          = mv_tnew;
                dir_right_next  = mv_tnew > rd_rec.tm;
                shift_only_next = 1'b0;
                j_next          = (mv_tnew > rd_rec.tm) ? JW'({1'b0, idx_reg} + 7'd1)
                                                        : JW'({1'b0, idx_reg} - 7'd1);
                state_next      = ST_LP_RD;
            end
            ST_LP_RD: begin
                ram_raddr = j_reg[AW-1:0];
                if (lp_end) begin
                    if (shift_only_reg) begin
                        n_next     = n_reg - CW'(1);
                        ok_next    = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_LP_WR;
                    end
                end else begin
                    state_next = ST_LP_CK;
                end
            end
            ST_LP_CK: begin
                if (lp_cond) begin
                    ram_we     = 1'b1;
                    ram_waddr  = lp_pos[AW-1:0];
                    ram_wrec   = rd_rec;
                    j_next     = dir_right_reg ? j_inc : j_dec;
                    state_next = ST_LP_RD;
                end else begin
                    state_next = ST_LP_WR;
                end
            end
            ST_LP_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = lp_pos[AW-1:0];
                ram_wrec   = '{tm: t_reg, val: kv_reg, wing_l: wl_reg, wing_r: wr_reg};
                if (cmd_reg == kfb_pkg::CMD_ADD) begin
                    n_next = n_reg + CW'(1);
                end
                ok_next    = 1'b1;
                state_next = ST_DONE;
            end
            ST_EV_RD: begin
                if (j_reg == $signed({1'b0, n_reg})) begin
                    ram_raddr  = AW'(1);
                    state_next = ST_EV_B1;
                end else begin
                    ram_raddr  = j_reg[AW-1:0];
                    state_next = ST_EV_CK;
                end
            end
            ST_EV_CK: begin
                if (rd_rec.tm >= t_reg) begin
                    tb_next  = rd_rec.tm;
                    vb_next  = rd_rec.val;
                    wlb_next = rd_rec.wing_l;
                    if (j_reg == '0) begin
                        ta_next  = rd_rec.tm;
                        va_next  = rd_rec.val;
                        wra_next = rd_rec.wing_r;
                    end
                    state_next = ST_DIV0;
                end else begin
                    ta_next    = rd_rec.tm;
                    va_next    = rd_rec.val;
                    wra_next   = rd_rec.wing_r;
                    j_next     = j_inc;
                    state_next = ST_EV_RD;
                end
            end
            ST_EV_B1: begin
                tb_next    = rd_rec.tm;
                vb_next    = rd_rec.val;
                wlb_next   = rd_rec.wing_l;
                state_next = ST_DIV0;
            end
            ST_DIV0: begin
                q0_next   = $signed({3'b000, va_reg});
                q1_next   = $signed({3'b000, va_reg}) + 19'(wra_reg);
                q2_next   = $signed({3'b000, vb_reg}) + 19'(wlb_reg);
                q3_next   = $signed({3'b000, vb_reg});
                step_next = '0;
                if ((dv_span <= 17'sd0) || (dv_diff <= 17'sd0)) begin
                    f_next     = '0;
                    state_next = ST_LMUL;
                end else if ({1'b0, dv_diff[15:1]} >= dv_span[15:0]) begin
                    f_next     = kfb_pkg::Q_ONE;
                    state_next = ST_LMUL;
                end else begin
                    rem_next     = {1'b0, dv_diff[15:1]};
                    d0_next      = dv_diff[0];
                    span_next    = dv_span[15:0];
                    quo_next     = '0;
                    bit_cnt_next = 4'd15;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next     = dv_ge ? dv_sub[15:0] : dv_rem2[15:0];
                quo_next     = dv_quo;
                bit_cnt_next = bit_cnt_reg - 4'd1;
                if (bit_cnt_reg == 4'd0) begin
                    f_next     = (dv_quo > kfb_pkg::Q_ONE) ? kfb_pkg::Q_ONE : dv_quo;
                    state_next = ST_LMUL;
                end
            end
            ST_LMUL: begin
                if (ln_drop) begin
                    q0_next   = q1_reg;
                    q1_next   = q2_reg;
                    q2_next   = q3_reg;
                    step_next = step_reg + 4'd1;
                end else begin
                    prod_next  = ln_prod;
                    state_next = ST_LADD;
                end
            end
            ST_LADD: begin
                q0_next = q1_reg;
                q1_next = q2_reg;
                q2_next = q3_reg;
                q3_next = ln_res;
                if (step_reg == 4'd8) begin
                    ok_next    = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    step_next  = step_reg + 4'd1;
                    state_next = ST_LMUL;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_value_next = (cmd_reg == kfb_pkg::CMD_EVAL) ? q3_reg[17:0] : 18'd0;
                    m_ok_next    = ok_reg;
                    m_count_next = 7'(n_reg);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT0;
            boot_reg    <= 1'b1;
            kv_reg      <= '0;
            ev_reg      <= '0;
            n_reg       <= CW'(2);
            ok_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            boot_reg    <= boot_next;
            kv_reg      <= kv_next;
            ev_reg      <= ev_next;
            n_reg       <= n_next;
            ok_reg      <= ok_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg        <= cmd_next;
        idx_reg        <= idx_next;
        kt_reg         <= kt_next;
        wl_reg         <= wl_next;
        wr_reg         <= wr_next;
        t_reg          <= t_next;
        j_reg          <= j_next;
        dir_right_reg  <= dir_right_next;
        shift_only_reg <= shift_only_next;
        prev_t_reg     <= prev_t_next;
        ta_reg         <= ta_next;
        tb_reg         <= tb_next;
        va_reg         <= va_next;
        vb_reg         <= vb_next;
        wra_reg        <= wra_next;
        wlb_reg        <= wlb_next;
        rem_reg        <= rem_next;
        span_reg       <= span_next;
        d0_reg         <= d0_next;
        quo_reg        <= quo_next;
        bit_cnt_reg    <= bit_cnt_next;
        f_reg          <= f_next;
        q0_reg         <= q0_next;
        q1_reg         <= q1_next;
        q2_reg         <= q2_next;
        q3_reg         <= q3_next;
        prod_reg       <= prod_next;
        step_reg       <= step_next;
        m_value_reg    <= m_value_next;
        m_ok_reg       <= m_ok_next;
        m_count_reg    <= m_count_next;
    end

    // Only the idle sequencer takes a new command transaction; the output register
    // lets it do so while the previous result is still waiting.
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_count_reg, m_value_reg};
    assign m_tuser  = m_ok_reg;

    // The key count always stays between the two end keys and a full table.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (n_reg >= CW'(2)) && (32'(n_reg) <= MAX_KEYS))
        else $error("key count out of range");

    // The key count moves by one key at a time, or back to two on init.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (n_reg != $past(n_reg)) |->
            ((n_reg == $past(n_reg) + CW'(1)) || (n_reg == $past(n_reg) - CW'(1)) ||
             (n_reg == CW'(2))))
        else $error("key count jumped");

    // The segment fraction fed to the lerp unit never exceeds one.
    a_frac_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LMUL) |-> (f_reg <= kfb_pkg::Q_ONE))
        else $error("segment fraction above one");

    // An accepted command always starts the sequencer.
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("command accepted but sequencer stayed idle");

endmodule

### test/tb_keyframe_bezier_curve.sv
// Self-checking testbench for the keyframe Bezier curve block with a built-in curve predictor.
module tb_keyframe_bezier_curve;

    localparam int NKEYS = 16;

    typedef struct {
        logic [2:0]         cmd;
        logic [5:0]         idx;
        logic signed [17:0] kt;
        logic signed [17:0] kv;
        logic signed [17:0] ev;
        logic signed [16:0] wl;
        logic signed [16:0] wr;
    } curve_cmd_t;

    typedef struct {
        logic signed [17:0] value;
        logic               ok;
        logic [6:0]         count;
    } curve_resp_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;

    keyframe_bezier_curve #(.MAX_KEYS(NKEYS)) u_dut (.*);

    always #4 aclk = ~aclk;

    // Shadow key table.
    int key_tm[NKEYS];
    int key_val[NKEYS];
    int key_wl[NKEYS];
    int key_wr[NKEYS];
    int key_cnt;

    curve_cmd_t  pending_cmds[$];
    curve_resp_t expected_resps[$];
    int          errors = 0;
    bit          all_sent = 0;
    int          hold_off = 0;
    bit          drain_req = 0;

    function automatic int clampi(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void table_reset();
        for (int i = 0; i < NKEYS; i++) begin
            key_tm[i] = 0; key_val[i] = 0; key_wl[i] = 0; key_wr[i] = 0;
        end
        key_tm[1] = 32768;
        key_cnt = 2;
    endfunction

    function automatic void sort_keys();
        int t;
        for (int n = key_cnt; n > 1; n--)
            for (int i = 1; i < n; i++)
                if (key_tm[i-1] > key_tm[i]) begin
                    t = key_tm[i-1];  key_tm[i-1] = key_tm[i];   key_tm[i] = t;
                    t = key_val[i-1]; key_val[i-1] = key_val[i]; key_val[i] = t;
                    t = key_wl[i-1];  key_wl[i-1] = key_wl[i];   key_wl[i] = t;
                    t = key_wr[i-1];  key_wr[i-1] = key_wr[i];   key_wr[i] = t;
                end
    endfunction

    // Lerp with round-half-up and floor division.
    function automatic longint lerp(longint a, longint b, longint f);
        longint x;
        x = (b - a) * f + 16384;
        return a + (x >= 0 ? x / 32768 : -((-x + 32767) / 32768));
    endfunction

    function automatic int curve_at(int t_in);
        int t, a, b;
        longint p1, p2, span, f, ab, bc, cd, abc, bcd;
        a = 0; b = 1;
        t = clampi(t_in, 0, 32768);
        for (int i = 0; i < key_cnt; i++) begin
            if (key_tm[i] >= t) begin
                b = i;
                break;
            end
            a = i;
        end
        p1 = key_val[a] + key_wr[a];
        p2 = key_val[b] + key_wl[b];
        span = longint'(key_tm[b]) - key_tm[a];
        f = 0;
        if (span > 0) f = ((longint'(t) - key_tm[a]) * 32768) / span;
        if (f < 0) f = 0;
        if (f > 32768) f = 32768;
        ab = lerp(key_val[a], p1, f);
        bc = lerp(p1, p2, f);
        cd = lerp(p2, key_val[b], f);
        abc = lerp(ab, bc, f);
        bcd = lerp(bc, cd, f);
        return int'(lerp(abc, bcd, f));
    endfunction

    function automatic curve_resp_t apply_cmd(curve_cmd_t c);
        curve_resp_t r;
        int kv, ev, wl, wr, lo, hi, t, ix;
        kv = clampi(c.kv, 0, 32768);
        ev = clampi(c.ev, 0, 32768);
        wl = clampi(c.wl, -32768, 32768);
        wr = clampi(c.wr, -32768, 32768);
        ix = c.idx;
        r.value = '0;
        r.ok = 1'b0;
        case (c.cmd)
            kfb_pkg::CMD_INIT: begin
                table_reset();
                key_val[0] = kv; key_val[1] = ev;
                r.ok = 1'b1;
            end
            kfb_pkg::CMD_ADD: if (key_cnt < NKEYS) begin
                key_tm[key_cnt] = clampi(c.kt, 655, 32113);
                key_val[key_cnt] = kv; key_wl[key_cnt] = wl; key_wr[key_cnt] = wr;
                key_cnt++;
                sort_keys();
                r.ok = 1'b1;
            end
            kfb_pkg::CMD_MOVE: if (ix < key_cnt) begin
                if (ix > 0 && ix + 1 < key_cnt) begin
                    lo = key_tm[ix-1] + 655;
                    hi = key_tm[ix+1] - 655;
                    // In a collapsed window, the upper bound wins unless kt is below lo.
                    t = c.kt < lo ? lo : (c.kt > hi ? hi : int'(c.kt));
                    key_tm[ix] = clampi(t, 0, 32768);
                end
                key_val[ix] = kv;
                sort_keys();
                r.ok = 1'b1;
            end
            kfb_pkg::CMD_REMOVE: if (ix > 0 && ix + 1 < key_cnt) begin
                for (int n = ix; n + 1 < key_cnt; n++) begin
                    key_tm[n] = key_tm[n+1]; key_val[n] = key_val[n+1];
                    key_wl[n] = key_wl[n+1]; key_wr[n] = key_wr[n+1];
                end
                key_cnt--;
                r.ok = 1'b1;
            end
            kfb_pkg::CMD_EVAL: begin
                r.value = 18'(curve_at(c.kt));
                r.ok = 1'b1;
            end
            kfb_pkg::CMD_WINGS: if (ix < key_cnt) begin
                key_wl[ix] = wl; key_wr[ix] = wr;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        r.count = 7'(key_cnt);
        return r;
    endfunction

    function automatic curve_cmd_t make_cmd(logic [2:0] op, int ix, int kt, int kv,
                                            int ev, int wl, int wr);
        curve_cmd_t c;
        c.cmd = op; c.idx = 6'(ix); c.kt = 18'(kt); c.kv = 18'(kv);
        c.ev = 18'(ev); c.wl = 17'(wl); c.wr = 17'(wr);
        return c;
    endfunction

    function automatic int rand_s18();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 32768);
            1: return int'($signed(18'($urandom)));
            2: return $urandom_range(0, 1) ? 32768 : 0;
            3: return $urandom_range(0, 1) ? 131071 : -131072;
            default: return $urandom_range(0, 32768);
        endcase
    endfunction

    function automatic int rand_wing();
        case ($urandom_range(0, 3))
            0: return int'($signed(17'($urandom)));
            1: return $urandom_range(0, 1) ? 32768 : -32768;
            default: return $urandom_range(0, 65536) - 32768;
        endcase
    endfunction

    // Mostly valid editing and evaluation traffic, some junk.
    function automatic curve_cmd_t rand_cmd();
        int w;
        logic [2:0] op;
        w = $urandom_range(0, 99);
        if (w < 3) op = kfb_pkg::CMD_INIT;
        else if (w < 28) op = kfb_pkg::CMD_ADD;
        else if (w < 40) op = kfb_pkg::CMD_MOVE;
        else if (w < 52) op = kfb_pkg::CMD_REMOVE;
        else if (w < 88) op = kfb_pkg::CMD_EVAL;
        else if (w < 97) op = kfb_pkg::CMD_WINGS;
        else op = 3'($urandom_range(6, 7));
        return make_cmd(op, $urandom_range(0, 3) == 0 ? $urandom_range(0, 63)
                                                     : $urandom_range(0, 17),
                        rand_s18(), rand_s18(), rand_s18(), rand_wing(), rand_wing());
    endfunction

    // Sender: bursts with random gaps, plus a pause for a full drain on request.
    int gap_left = 0;
    int burst_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_resps.push_back(apply_cmd(pending_cmds.pop_front()));
            end
            if (s_tvalid && !s_tready) begin
                // Hold the offered transaction.
            end else if (gap_left > 0 || pending_cmds.size() == 0 ||
                         (drain_req && expected_resps.size() != 0)) begin
                s_tvalid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata  <= {2'b00, pending_cmds[0].wr, pending_cmds[0].wl, pending_cmds[0].ev,
                             pending_cmds[0].kv, pending_cmds[0].kt, pending_cmds[0].idx};
                s_tuser  <= pending_cmds[0].cmd;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Receiver: its own stall pattern, plus one long hold-off.
    int stall_phase = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            stall_phase <= stall_phase + 1;
            if (stall_phase == 200) begin
                hold_off <= 400;
                m_tready <= 1'b0;
            end else if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_tready <= 1'b0;
            end else if ((stall_phase / 64) % 3 == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= $urandom_range(0, 3) != 0;
            end
        end
    end

    // Monitor: compares each result transaction with the oldest prediction.
    always @(posedge aclk) begin
        curve_resp_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_resps.size() == 0) begin
                $display("%0t: unexpected result value=%0d ok=%0d count=%0d", $time,
                         $signed(m_tdata[17:0]), m_tuser[0], m_tdata[24:18]);
                errors++;
            end else begin
                e = expected_resps.pop_front();
                if (m_tdata[17:0] !== e.value) begin
                    $display("%0t: curve_value expected %0d actual %0d", $time,
                             e.value, $signed(m_tdata[17:0]));
                    errors++;
                end
                if (m_tuser[0] !== e.ok) begin
                    $display("%0t: ok expected %0d actual %0d", $time, e.ok, m_tuser[0]);
                    errors++;
                end
                if (m_tdata[24:18] !== e.count) begin
                    $display("%0t: count_now expected %0d actual %0d", $time,
                             e.count, m_tdata[24:18]);
                    errors++;
                end
            end
        end
    end

    initial begin
        table_reset();
        // Directed: extremes, every command, full table, end keys, bad indexes.
        pending_cmds.push_back(make_cmd(kfb_pkg::CMD_EVAL, 0, 16384, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(kfb_pkg::CMD_INIT, 0, 0, -131072, 131071, 0, 0));
        pending_cmds.push_back(make_cmd(kfb_pkg::CMD_INIT, 0, 0, 8000, 30000, 0, 0));
        pending_cmds.push_back(make_cmd(kfb_pkg::CMD_WINGS, 0, 0, 0, 0, -65536, 65535));
        pending_cmds.push_back(make_cmd(kfb_pkg::CMD_WINGS, 1, 0, 0, 0, 32768, -32768));
        pending_cmds.push_back(make_cmd(kfb_pkg::CMD_EVAL, 0, -131072, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(kfb_pkg::CMD_EVAL, 0, 131071, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(kfb_pkg::CMD_EVAL, 0, 12345, 0, 0, 0, 0));
        for (int i = 0; i < 15; i++)
            pending_cmds.push_back(make_cmd(kfb_pkg::CMD_ADD, 0, i < 3 ? -131072 : 2000 * i,
                                            3000 * i, 0, -32768 + 5000 * i, 1000 * i));
        pending_cmds.push_back(make_cmd(kfb_pkg::CMD_EVAL, 0, 655, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(kfb_pkg::CMD_MOVE, 2, 0, 100, 0, 0, 0));
        pending_cmds.push_back(make_cmd(kfb_pkg::CMD_MOVE, 0, 20000, 32768, 0, 0, 0));
        pending_cmds.push_back(make_cmd(kfb_pkg::CMD_MOVE, 15, 0, 1, 0, 0, 0));
        pending_cmds.push_back(make_cmd(kfb_pkg::CMD_MOVE, 5, 131071, 7, 0, 0, 0));
        pending_cmds.push_back(make_cmd(kfb_pkg::CMD_REMOVE, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(kfb_pkg::CMD_REMOVE, 15, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(kfb_pkg::CMD_REMOVE, 63, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(kfb_pkg::CMD_REMOVE, 3, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(kfb_pkg::CMD_WINGS, 63, 0, 0, 0, 0, 0));
        // The two unused command codes just above CMD_WINGS are refused.
        pending_cmds.push_back(make_cmd(3'(kfb_pkg::CMD_WINGS + 3'd1), 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(3'(kfb_pkg::CMD_WINGS + 3'd2), 63, 0, 0, 0, 0, 0));
        for (int i = 0; i < 300; i++) pending_cmds.push_back(rand_cmd());

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // The receiver holds off for a long stretch while the sender keeps offering.
        wait (pending_cmds.size() < 150);
        // Pause the sender until the block has fully drained.
        drain_req <= 1'b1;
        wait (expected_resps.size() == 0);
        @(posedge aclk);
        drain_req <= 1'b0;
        for (int i = 0; i < 300; i++) pending_cmds.push_back(rand_cmd());

        wait (pending_cmds.size() == 0 && !(s_tvalid && !s_tready));
        wait (expected_resps.size() == 0);
        repeat (100) @(posedge aclk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
